// File: sv/uer_pkg.sv
// shared types and constants for the ultrasonic echo ranger
// no dependencies; imported by every module of the block
package uer_pkg;

	// register map
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CALIBRATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE       = 3'd4;

	// field widths
	localparam int CAL_W  = 16;
	localparam int DIST_W = 10;
	localparam int TICK_W = 14;

	// register reset values
	localparam logic [CAL_W-1:0]  CAL_RST    = 16'd0;
	localparam logic [DIST_W-1:0] MAX_RST    = 10'd400;
	localparam logic [DIST_W-1:0] ZONE_RST   = 10'd20;
	localparam logic [TICK_W-1:0] SETTLE_RST = 14'd2000;
	localparam logic [TICK_W-1:0] PULSE_RST  = 14'd10000;

	// microseconds to centimeters: count / 58.2 as (count * 1126) >> 16
	localparam int CM_MULT_W = 11;
	localparam logic [CM_MULT_W-1:0] CM_MULT = 11'd1126;
	localparam int CM_SHIFT = 16;

	// measurement sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SETTLE,
		PH_PULSE,
		PH_RISE,
		PH_FALL
	} phase_t;

	// configuration register set
	typedef struct packed {
		logic [CAL_W-1:0]  calibration_us;
		logic [DIST_W-1:0] max_distance_cm;
		logic [DIST_W-1:0] zone_cm;
		logic [TICK_W-1:0] settle_ticks;
		logic [TICK_W-1:0] pulse_ticks;
	} cfg_t;

	// per-tick status from the sequencer
	typedef struct packed {
		logic trigger;
		logic busy;
		logic done;
	} flags_t;

endpackage

// File: sv/ultrasonic_echo_ranger.sv
// Ultrasonic time-of-flight ranger. Each input transaction is one microsecond tick carrying
// a start request and the sampled echo level; each tick yields exactly one result
// transaction with the trigger drive, busy, done, the stored distance in centimeters and
// the zone flag. One tick is taken every clock while the output side is not stalled;
// a result passes through the sequencer stage, the conversion multiply stage and the result
// register, and an output stall holds the whole pipeline.
// Depends on uer_pkg, uer_cfg, uer_ctrl and uer_conv.
module ultrasonic_echo_ranger
	import uer_pkg::*;
#(
	parameter int DURATION_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// tick input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  start_req,
	input  logic                  echo,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  trigger,
	output logic                  busy_res,
	output logic                  done_res,
	output logic [DIST_W-1:0]     distance_cm,
	output logic                  in_zone
);

	cfg_t                     cfg;
	logic                     adv, take, v_s1;
	flags_t                   flags_s1;
	logic [DURATION_BITS-1:0] dur_s1;

	// pipeline moves unless a finished result is held by the output side
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign take     = in_valid && adv;

	uer_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uer_ctrl #(
		.DURATION_BITS (DURATION_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.take      (take),
		.start_req (start_req),
		.echo      (echo),
		.cfg       (cfg),
		.v_s1      (v_s1),
		.flags_s1  (flags_s1),
		.dur_s1    (dur_s1)
	);

	uer_conv #(
		.DURATION_BITS (DURATION_BITS)
	) u_conv (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.v_s1        (v_s1),
		.flags_s1    (flags_s1),
		.dur_s1      (dur_s1),
		.cfg         (cfg),
		.out_valid   (out_valid),
		.trigger     (trigger),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.distance_cm (distance_cm),
		.in_zone     (in_zone)
	);

endmodule

// File: sv/uer_cfg.sv
// configuration register file of the ultrasonic echo ranger
// depends on uer_pkg
module uer_cfg
	import uer_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// write port, unknown indices are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.calibration_us  <= CAL_RST;
			cfg_q.max_distance_cm <= MAX_RST;
			cfg_q.zone_cm         <= ZONE_RST;
			cfg_q.settle_ticks    <= SETTLE_RST;
			cfg_q.pulse_ticks     <= PULSE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CALIBRATION: cfg_q.calibration_us  <= cfg_data[CAL_W-1:0];
				REG_MAX_DIST:    cfg_q.max_distance_cm <= cfg_data[DIST_W-1:0];
				REG_ZONE:        cfg_q.zone_cm         <= cfg_data[DIST_W-1:0];
				REG_SETTLE:      cfg_q.settle_ticks    <= cfg_data[TICK_W-1:0];
				REG_PULSE:       cfg_q.pulse_ticks     <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/uer_ctrl.sv
// measurement sequencer: trigger timing and echo duration count, first pipeline stage
// depends on uer_pkg
module uer_ctrl
	import uer_pkg::*;
#(
	parameter int DURATION_BITS = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     take,
	input  logic                     start_req,
	input  logic                     echo,
	input  cfg_t                     cfg,
	output logic                     v_s1,
	output flags_t                   flags_s1,
	output logic [DURATION_BITS-1:0] dur_s1
);

	localparam logic [DURATION_BITS-1:0] DUR_MAX = '1;

	phase_t                   phase_q, phase_d;
	logic [TICK_W-1:0]        cnt_q, cnt_d, cnt_inc;
	logic [DURATION_BITS-1:0] dur_q, dur_d, dur_inc;
	logic                     done_d;
	flags_t                   flags_d;

	assign cnt_inc = cnt_q + 1'b1;
	assign dur_inc = (dur_q < DUR_MAX) ? dur_q + 1'b1 : dur_q;

	// next state for one tick
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		dur_d   = dur_q;
		done_d  = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					phase_d = PH_SETTLE;
					cnt_d   = '0;
					dur_d   = '0;
				end
			end
			PH_SETTLE: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= cfg.settle_ticks) begin
					phase_d = PH_PULSE;
					cnt_d   = '0;
				end
			end
			PH_PULSE: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= cfg.pulse_ticks) begin
					phase_d = PH_RISE;
					cnt_d   = '0;
					dur_d   = '0;
				end
			end
			PH_RISE: begin
				dur_d = dur_inc;
				if (echo) begin
					phase_d = PH_FALL;
				end
			end
			PH_FALL: begin
				dur_d = dur_inc;
				if (!echo) begin
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// status seen after the tick
	always_comb begin
		flags_d.trigger = (phase_d == PH_PULSE);
		flags_d.busy    = (phase_d != PH_IDLE);
		flags_d.done    = done_d;
	end

	// sequencer state, moves only on an accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			dur_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			dur_q   <= dur_d;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			flags_s1 <= flags_d;
			dur_s1   <= dur_d;
		end
	end

endmodule

// File: sv/uer_conv.sv
// duration to distance conversion (stage 2) and result register (stage 3)
// depends on uer_pkg
module uer_conv
	import uer_pkg::*;
#(
	parameter int DURATION_BITS = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     v_s1,
	input  flags_t                   flags_s1,
	input  logic [DURATION_BITS-1:0] dur_s1,
	input  cfg_t                     cfg,
	output logic                     out_valid,
	output logic                     trigger,
	output logic                     busy_res,
	output logic                     done_res,
	output logic [DIST_W-1:0]        distance_cm,
	output logic                     in_zone
);

	localparam int PROD_W = DURATION_BITS + CM_MULT_W;
	localparam int CM_W   = PROD_W - CM_SHIFT;

	logic [DURATION_BITS-1:0] cal_ext, corr;
	logic [PROD_W-1:0]        prod_s2;
	logic                     v_s2;
	flags_t                   flags_s2;
	logic [CM_W-1:0]          cm;
	logic [DIST_W-1:0]        dist_new, dist_next;

	// calibration subtract, floored at zero
	assign cal_ext = DURATION_BITS'(cfg.calibration_us);
	assign corr    = (dur_s1 > cal_ext) ? dur_s1 - cal_ext : '0;

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	// stage 2 payload: fixed point scale
	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s2 <= flags_s1;
			prod_s2  <= PROD_W'(corr) * PROD_W'(CM_MULT);
		end
	end

	// clamp to the maximum distance
	assign cm       = prod_s2[PROD_W-1:CM_SHIFT];
	assign dist_new = (cm > CM_W'(cfg.max_distance_cm)) ? cfg.max_distance_cm
		: cm[DIST_W-1:0];
	assign dist_next = (v_s2 && flags_s2.done) ? dist_new : distance_cm;

	// result register control and stored distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			distance_cm <= '0;
		end else if (adv) begin
			out_valid   <= v_s2;
			distance_cm <= dist_next;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			trigger  <= flags_s2.trigger;
			busy_res <= flags_s2.busy;
			done_res <= flags_s2.done;
			in_zone  <= (cfg.zone_cm > dist_next);
		end
	end

endmodule

// File: sv/uer_checker.sv
// port-level checks for the ultrasonic echo ranger, bound to the top level
// depends on uer_pkg and ultrasonic_echo_ranger
module uer_checker
	import uer_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  trigger,
	input logic                  busy_res,
	input logic                  done_res,
	input logic [DIST_W-1:0]     distance_cm,
	input logic                  in_zone
);

	// a finished measurement reports idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done result while still busy");

	// trigger is only driven inside a measurement
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger |-> busy_res && !done_res)
		else $error("trigger high outside pulse phase");

	// input is held back only by a stalled result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a stalled result transaction keeps its distance
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance_cm) && $stable(in_zone))
		else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.trigger     (trigger),
	.busy_res    (busy_res),
	.done_res    (done_res),
	.distance_cm (distance_cm),
	.in_zone     (in_zone)
);

// File: bench/echo_ranger_check.sv
`timescale 1ns / 100ps
// result checker for the ultrasonic echo ranger: tracks register writes and accepted ticks,
// predicts each result transaction and compares it field by field; depends on uer_pkg
module echo_ranger_check
	import uer_pkg::*;
#(
	parameter int DURATION_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  start_req,
	input  logic                  echo,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  trigger,
	input  logic                  busy_res,
	input  logic                  done_res,
	input  logic [DIST_W-1:0]     distance_cm,
	input  logic                  in_zone,
	output int                    mismatches,
	output int                    outstanding
);

	// one predicted result transaction
	typedef struct packed {
		logic              trigger;
		logic              busy;
		logic              done;
		logic [DIST_W-1:0] distance;
		logic              zone;
	} reading_t;

	// shadow registers and sequencer state
	cfg_t                     ranger_cfg;
	phase_t                   seq_phase;
	logic [TICK_W-1:0]        seq_count;
	logic [DURATION_BITS-1:0] flight_ticks;
	logic [DIST_W-1:0]        stored_dist;
	reading_t                 pending_readings[$];
	int                       error_total = 0;

	// one line per failure, quiet after the first 40
	task automatic report_mismatch(input string what);
		if (error_total < 40) begin
			$display("mismatch at %0t: %s", $time, what);
		end
		error_total++;
	endtask

	// compare, track registers, then advance the ranging sequencer per accepted tick
	always @(posedge clk or negedge arst_n) begin : tof_tracker
		reading_t                           want;
		reading_t                           got;
		logic [DURATION_BITS-1:0]           corrected;
		logic [DURATION_BITS+CM_MULT_W-1:0] scaled;
		if (!arst_n) begin
			ranger_cfg.calibration_us  = CAL_RST;
			ranger_cfg.max_distance_cm = MAX_RST;
			ranger_cfg.zone_cm         = ZONE_RST;
			ranger_cfg.settle_ticks    = SETTLE_RST;
			ranger_cfg.pulse_ticks     = PULSE_RST;
			seq_phase    = PH_IDLE;
			seq_count    = '0;
			flight_ticks = '0;
			stored_dist  = '0;
			pending_readings.delete();
			outstanding <= 0;
			mismatches  <= error_total;
		end else begin
			// result side: oldest prediction first
			if (out_valid && !out_stall) begin
				got = {trigger, busy_res, done_res, distance_cm, in_zone};
				if (pending_readings.size() == 0) begin
					report_mismatch($sformatf("result transaction with nothing pending (%h)", got));
				end else begin
					want = pending_readings.pop_front();
					if (got.trigger !== want.trigger)
						report_mismatch($sformatf("trigger %b, expected %b", got.trigger, want.trigger));
					if (got.busy !== want.busy)
						report_mismatch($sformatf("busy_res %b, expected %b", got.busy, want.busy));
					if (got.done !== want.done)
						report_mismatch($sformatf("done_res %b, expected %b", got.done, want.done));
					if (got.distance !== want.distance)
						report_mismatch($sformatf("distance_cm %0d, expected %0d",
							got.distance, want.distance));
					if (got.zone !== want.zone)
						report_mismatch($sformatf("in_zone %b, expected %b", got.zone, want.zone));
				end
			end

			// register writes, masked to width, unknown indexes dropped
			if (cfg_we) begin
				case (cfg_index)
					REG_CALIBRATION: ranger_cfg.calibration_us  = cfg_data[CAL_W-1:0];
					REG_MAX_DIST:    ranger_cfg.max_distance_cm = cfg_data[DIST_W-1:0];
					REG_ZONE:        ranger_cfg.zone_cm         = cfg_data[DIST_W-1:0];
					REG_SETTLE:      ranger_cfg.settle_ticks    = cfg_data[TICK_W-1:0];
					REG_PULSE:       ranger_cfg.pulse_ticks     = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end

			// sequencer step for one accepted tick
			if (in_valid && !in_stall) begin
				want.done = 1'b0;
				case (seq_phase)
					PH_IDLE: begin
						if (start_req) begin
							seq_phase    = PH_SETTLE;
							seq_count    = '0;
							flight_ticks = '0;
						end
					end
					PH_SETTLE: begin
						seq_count = seq_count + 1'b1;
						if (seq_count >= ranger_cfg.settle_ticks) begin
							seq_phase = PH_PULSE;
							seq_count = '0;
						end
					end
					PH_PULSE: begin
						seq_count = seq_count + 1'b1;
						if (seq_count >= ranger_cfg.pulse_ticks) begin
							seq_phase    = PH_RISE;
							seq_count    = '0;
							flight_ticks = '0;
						end
					end
					PH_RISE, PH_FALL: begin
						// saturating time of flight, including the tick that sees the fall
						if (flight_ticks != '1)
							flight_ticks = flight_ticks + 1'b1;
						if (seq_phase == PH_RISE) begin
							if (echo)
								seq_phase = PH_FALL;
						end else if (!echo) begin
							// calibrate, scale by 1126/65536 (about 1/58.2), clamp
							corrected = (flight_ticks > ranger_cfg.calibration_us) ?
								flight_ticks - ranger_cfg.calibration_us : '0;
							scaled = (corrected * CM_MULT) >> CM_SHIFT;
							stored_dist = (scaled > ranger_cfg.max_distance_cm) ?
								ranger_cfg.max_distance_cm : scaled[DIST_W-1:0];
							want.done = 1'b1;
							seq_phase = PH_IDLE;
						end
					end
					default: seq_phase = PH_IDLE;
				endcase
				want.trigger  = (seq_phase == PH_PULSE);
				want.busy     = (seq_phase != PH_IDLE);
				want.distance = stored_dist;
				want.zone     = (ranger_cfg.zone_cm > stored_dist);
				pending_readings.push_back(want);
			end

			outstanding <= pending_readings.size();
			mismatches  <= error_total;
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// top of the ultrasonic echo ranger bench: clock, reset, tick stimulus, register
// programming and verdict; depends on uer_pkg, ultrasonic_echo_ranger, echo_ranger_check
module testbench;
	import uer_pkg::*;

	localparam int DURATION_BITS = 20;
	localparam int RANDOM_TICKS  = 1200;
	localparam int PHASE_TICKS   = 220;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  start_req = 1'b0;
	logic                  echo = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  trigger;
	logic                  busy_res;
	logic                  done_res;
	logic [DIST_W-1:0]     distance_cm;
	logic                  in_zone;
	int                    mismatches;
	int                    outstanding;

	// sender bookkeeping and stimulus-side copy of the phase lengths
	int           settle_len = SETTLE_RST;
	int           pulse_len = PULSE_RST;
	int           burst_left = 0;
	bit           gaps_on = 1'b1;
	int           tick_total = 0;
	int           measure_total = 0;
	int           phase_total = 0;
	stall_style_t stall_style = STALL_NONE;
	int           stall_left = 0;

	always #2 clk = ~clk;

	ultrasonic_echo_ranger #(
		.DURATION_BITS(DURATION_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_req(start_req),
		.echo(echo),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.trigger(trigger),
		.busy_res(busy_res),
		.done_res(done_res),
		.distance_cm(distance_cm),
		.in_zone(in_zone)
	);

	echo_ranger_check #(
		.DURATION_BITS(DURATION_BITS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_req(start_req),
		.echo(echo),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.trigger(trigger),
		.busy_res(busy_res),
		.done_res(done_res),
		.distance_cm(distance_cm),
		.in_zone(in_zone),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// receiver stall: a new random style each time the stall countdown runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style <= stall_style_t'($urandom_range(0, 3));
			stall_left  <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: out_stall <= (stall_left % 5 < 2);
			default:        out_stall <= 1'b0;
		endcase
	end

	// one tick transaction, then an idle gap when the burst runs out
	task automatic send_tick(input logic start_lvl, input logic echo_lvl);
		in_valid  <= 1'b1;
		start_req <= start_lvl;
		echo      <= echo_lvl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tick_total++;
		burst_left--;
		if (gaps_on && burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	// hold off the sender until every predicted result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// one register write with junk above the register width
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val,
		input int width);
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'(($urandom << width) | (val & ((1 << width) - 1)));
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		if (idx == REG_SETTLE)
			settle_len = word[TICK_W-1:0];
		if (idx == REG_PULSE)
			pulse_len = word[TICK_W-1:0];
		@(posedge clk);
	endtask

	// drain, then load the whole register set
	task automatic program_phase(input int unsigned cal, input int unsigned maxd,
		input int unsigned zone, input int unsigned settle, input int unsigned pulse,
		input bit junk);
		drain_results();
		write_reg(REG_CALIBRATION, cal, CAL_W);
		write_reg(REG_MAX_DIST, maxd, DIST_W);
		write_reg(REG_ZONE, zone, DIST_W);
		write_reg(REG_SETTLE, settle, TICK_W);
		write_reg(REG_PULSE, pulse, TICK_W);
		if (junk) begin
			for (int i = REG_PULSE + 1; i < 2 ** CFG_IDX_W; i++)
				write_reg(CFG_IDX_W'(i), $urandom, CFG_DATA_W);
		end
		cfg_we <= 1'b0;
		phase_total++;
	endtask

	// start, ride out settle and pulse with noise, then a well-formed echo
	task automatic run_measurement(input int rise_wait, input int echo_high);
		send_tick(1'b1, $urandom_range(0, 1));
		repeat ((settle_len == 0 ? 1 : settle_len) + (pulse_len == 0 ? 1 : pulse_len))
			send_tick($urandom_range(0, 1), $urandom_range(0, 1));
		repeat (rise_wait)
			send_tick($urandom_range(0, 1), 1'b0);
		repeat (echo_high)
			send_tick($urandom_range(0, 1), 1'b1);
		send_tick($urandom_range(0, 1), 1'b0);
		measure_total++;
	endtask

	// run limit
	initial begin
		#(1_000_000);
		$display("timeout with %0d results outstanding", outstanding);
		$display("status: fail");
		$finish;
	end

	initial begin
		int random_ticks;
		int phase_mark;
		int mark;
		int rise_wait;
		int echo_high;
		random_ticks = 0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: echo while idle, start, part of the settle phase
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		repeat (20)
			send_tick($urandom_range(0, 1), $urandom_range(0, 1));

		// shorten the phases mid-measurement and finish it, then zero lengths,
		// unused indexes, echo already high, back-to-back starts
		program_phase(0, 1023, 1023, 0, 0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		repeat (5)
			send_tick($urandom_range(0, 1), 1'b0);
		repeat (30)
			send_tick($urandom_range(0, 1), 1'b1);
		send_tick($urandom_range(0, 1), 1'b0);
		measure_total++;
		run_measurement(0, 1);
		run_measurement(0, 120);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		drain_results();

		// calibration above the count, zone threshold at zero
		program_phase(65535, 1023, 0, 1, 1, 1'b0);
		run_measurement(10, 60);

		// longest settle and pulse cut short mid-settle, clamp to zero distance
		program_phase(0, 0, 1, 16383, 16383, 1'b0);
		send_tick(1'b1, 1'b0);
		repeat (30)
			send_tick($urandom_range(0, 1), 1'b0);
		program_phase(0, 0, 1, 40, 2, 1'b0);
		repeat (12)
			send_tick($urandom_range(0, 1), 1'b0);
		repeat (3)
			send_tick($urandom_range(0, 1), 1'b0);
		repeat (40)
			send_tick($urandom_range(0, 1), 1'b1);
		send_tick($urandom_range(0, 1), 1'b0);
		measure_total++;

		// random phases of well-formed measurements with noise between them
		while (random_ticks < RANDOM_TICKS) begin
			program_phase(
				($urandom_range(0, 2) == 0) ? $urandom_range(0, 150) : 0,
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 9),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 9),
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5),
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5),
				$urandom_range(0, 3) == 0);
			gaps_on = ($urandom_range(0, 3) != 0);
			phase_mark = tick_total;
			while (tick_total - phase_mark < PHASE_TICKS) begin
				if ($urandom_range(0, 7) == 0) begin
					repeat ($urandom_range(1, 4))
						send_tick(1'b0, $urandom_range(0, 1));
				end
				rise_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: echo_high = $urandom_range(1, 60);
					6, 7, 8:          echo_high = $urandom_range(61, 250);
					default:          echo_high = $urandom_range(251, 600);
				endcase
				mark = tick_total;
				run_measurement(rise_wait, echo_high);
				random_ticks += tick_total - mark;
			end
		end

		// wind down
		drain_results();
		repeat (8)
			@(posedge clk);
		$display("ran %0d ticks in %0d measurements over %0d register settings",
			tick_total, measure_total, phase_total);
		$display("settings spanned reset values, zero and full-scale phase lengths, "
			, "clamp, zone and calibration extremes");
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/uer_pkg.sv
sv/uer_cfg.sv
sv/uer_ctrl.sv
sv/uer_conv.sv
sv/ultrasonic_echo_ranger.sv
sv/uer_checker.sv
bench/echo_ranger_check.sv
bench/testbench.sv
